// ===== rtl/pvb_pkg.sv =====
// Shared constants for the phase vocoder bin update block.
// Used by the channel interfaces and by the top level.
package pvb_pkg;

  // Default width of every sample field, signed Q1.15 at 16 bits.
  localparam int unsigned SampleWidthDef = 16;

endpackage

// ===== rtl/pvb_in_if.sv =====
// Input channel of the bin update block: three complex bins and the real-only flag.
// Depends on pvb_pkg for the default sample width.
interface pvb_in_if #(
  parameter int unsigned SAMPLE_WIDTH = pvb_pkg::SampleWidthDef
);
  import pvb_pkg::*;

  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] start_re;
  logic signed [SAMPLE_WIDTH-1:0] start_im;
  logic signed [SAMPLE_WIDTH-1:0] end_re;
  logic signed [SAMPLE_WIDTH-1:0] end_im;
  logic signed [SAMPLE_WIDTH-1:0] prev_re;
  logic signed [SAMPLE_WIDTH-1:0] prev_im;
  logic                           real_only;

  modport source (
    output valid, start_re, start_im, end_re, end_im, prev_re, prev_im, real_only,
    input  ready
  );
  modport sink (
    input  valid, start_re, start_im, end_re, end_im, prev_re, prev_im, real_only,
    output ready
  );
endinterface

// ===== rtl/pvb_out_if.sv =====
// Output channel of the bin update block: the new synthesis bin and its flag.
// Depends on pvb_pkg for the default sample width.
interface pvb_out_if #(
  parameter int unsigned SAMPLE_WIDTH = pvb_pkg::SampleWidthDef
);
  import pvb_pkg::*;

  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] out_re;
  logic signed [SAMPLE_WIDTH-1:0] out_im;
  logic                           degenerate;

  modport source (output valid, out_re, out_im, degenerate, input ready);
  modport sink (input valid, out_re, out_im, degenerate, output ready);
endinterface

// ===== rtl/phase_vocoder_bin_update_unit.sv =====
// Top level of the phase vocoder bin update: a deep pipeline that rotates the end bin
// by the unit phasor of prev * conj(start). Depends on pvb_pkg, pvb_in_if, pvb_out_if.
//
//   channel | dir | contents                                  | request taken when
//   req_i   | in  | start, end, prev bins (re/im), real_only  | valid && ready
//   rsp_o   | out | out_re, out_im, degenerate                | valid && ready
//
// One bin enters per cycle unless a stalled output has backed the pipeline up. The
// depth, with NB = min(62 - SAMPLE_WIDTH, 31), is set by the
// square root (two root bits per stage) and the two dividers (two quotient bits per stage).
// Reset clears only the stage valid bits. Every stage holds its request while the next
// one is full and stalled, so a stalled output fills empty stages before the input stops.
module phase_vocoder_bin_update_unit #(
  parameter int unsigned SAMPLE_WIDTH = pvb_pkg::SampleWidthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pvb_in_if.sink     req_i,
  pvb_out_if.source  rsp_o
);
  import pvb_pkg::*;

  localparam int SW   = SAMPLE_WIDTH;
  localparam int NB   = ((62 - SW) < 31) ? (62 - SW) : 31;
  localparam int PW   = 2 * SW;
  localparam int MW   = 2 * SW;
  localparam int XW   = (MW > NB) ? MW : NB;
  localparam int SMAX = (MW > NB) ? (MW - NB) : 0;
  localparam int SHW  = (SMAX > 0) ? $clog2(SMAX + 1) : 1;
  localparam int RW   = 2 * NB + 2;
  localparam int XPW  = SW + NB + 1;
  localparam int NW   = SW + NB + 2;
  localparam int DW   = NW + 1;
  localparam int QB   = SW + 2;
  localparam int SQS  = (NB + 2) / 2;
  localparam int DVS  = (QB + 1) / 2;

  localparam int IdxS1  = 0;
  localparam int IdxS2  = 1;
  localparam int IdxS3  = 2;
  localparam int IdxS4  = 3;
  localparam int IdxS5  = 4;
  localparam int IdxSq  = 5;
  localparam int IdxDv0 = 5 + SQS;
  localparam int IdxDv  = 6 + SQS;
  localparam int IdxOut = 6 + SQS + DVS;
  localparam int NST    = 7 + SQS + DVS;

  typedef struct packed {
    logic          ro;
    logic          deg;
    logic [SW-1:0] ro_val;
  } side_t;

  typedef struct packed {
    side_t                sd;
    logic signed [SW-1:0] er;
    logic signed [SW-1:0] ei;
    logic signed [PW-1:0] p_rr;
    logic signed [PW-1:0] p_ii;
    logic signed [PW-1:0] p_ir;
    logic signed [PW-1:0] p_ri;
  } s1_t;

  typedef struct packed {
    side_t                sd;
    logic signed [SW-1:0] er;
    logic signed [SW-1:0] ei;
    logic                 nr;
    logic                 ni;
    logic [MW-1:0]        ar;
    logic [MW-1:0]        ai;
  } s2_t;

  typedef struct packed {
    side_t                sd;
    logic signed [SW-1:0] er;
    logic signed [SW-1:0] ei;
    logic [NB-1:0]        an_r;
    logic [NB-1:0]        an_i;
    logic signed [NB:0]   wr;
    logic signed [NB:0]   wi;
  } s3_t;

  typedef struct packed {
    side_t                 sd;
    logic [2*NB-1:0]       sq_r;
    logic [2*NB-1:0]       sq_i;
    logic signed [XPW-1:0] x_rr;
    logic signed [XPW-1:0] x_ii;
    logic signed [XPW-1:0] x_ri;
    logic signed [XPW-1:0] x_ir;
  } s4_t;

  typedef struct packed {
    side_t                sd;
    logic [RW-1:0]        rad;
    logic signed [NW-1:0] num_re;
    logic signed [NW-1:0] num_im;
  } s5_t;

  typedef struct packed {
    side_t         sd;
    logic [RW-1:0] rad;
    logic [NB:0]   root;
    logic [NB+2:0] rem;
    logic [NW-1:0] mag_re;
    logic [NW-1:0] mag_im;
    logic          neg_re;
    logic          neg_im;
  } sq_t;

  typedef struct packed {
    side_t         sd;
    logic [NB:0]   m;
    logic [NB+1:0] r_re;
    logic [NB+1:0] r_im;
    logic [QB-1:0] dl_re;
    logic [QB-1:0] dl_im;
    logic [QB-1:0] q_re;
    logic [QB-1:0] q_im;
    logic          neg_re;
    logic          neg_im;
  } dv_t;

  typedef struct packed {
    logic signed [SW-1:0] out_re;
    logic signed [SW-1:0] out_im;
    logic                 degenerate;
  } out_t;

  // Stage valid bits and per-stage advance; a stage loads when it is empty
  // or its contents move on in the same cycle.
  logic [NST-1:0] v_q, v_d;
  logic [NST-1:0] adv;

  always_comb begin
    adv[NST-1] = !v_q[NST-1] || rsp_o.ready;
    for (int k = NST - 2; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
    v_d[0] = adv[0] ? req_i.valid : v_q[0];
    for (int k = 1; k < NST; k++) begin
      if (adv[k]) begin
        v_d[k] = v_q[k-1];
      end else begin
        v_d[k] = v_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign req_i.ready = adv[0];

  // Stage 1: cross products of prev and conj(start), degenerate and real-only cases.
  s1_t s1_d, s1_q;
  always_comb begin
    logic flip;
    flip = req_i.start_re[SW-1] ^ req_i.prev_re[SW-1];
    s1_d.sd.ro = req_i.real_only;
    if (req_i.real_only) begin
      s1_d.sd.deg = (req_i.start_re == '0) || (req_i.prev_re == '0);
    end else begin
      s1_d.sd.deg = ((req_i.start_re == '0) && (req_i.start_im == '0)) ||
                    ((req_i.prev_re == '0) && (req_i.prev_im == '0));
    end
    if (!flip) begin
      s1_d.sd.ro_val = req_i.end_re;
    end else if (req_i.end_re == {1'b1, {(SW-1){1'b0}}}) begin
      s1_d.sd.ro_val = {1'b0, {(SW-1){1'b1}}};
    end else begin
      s1_d.sd.ro_val = -req_i.end_re;
    end
    s1_d.er   = req_i.end_re;
    s1_d.ei   = req_i.end_im;
    s1_d.p_rr = PW'(req_i.prev_re) * PW'(req_i.start_re);
    s1_d.p_ii = PW'(req_i.prev_im) * PW'(req_i.start_im);
    s1_d.p_ir = PW'(req_i.prev_im) * PW'(req_i.start_re);
    s1_d.p_ri = PW'(req_i.prev_re) * PW'(req_i.start_im);
  end

  always_ff @(posedge clk_i) begin
    if (adv[IdxS1]) s1_q <= s1_d;
  end

  // Stage 2: W = P * conj(S) in sign and magnitude.
  s2_t s2_d, s2_q;
  always_comb begin
    logic signed [PW:0] w_re;
    logic signed [PW:0] w_im;
    w_re = (PW+1)'(s1_q.p_rr) + (PW+1)'(s1_q.p_ii);
    w_im = (PW+1)'(s1_q.p_ir) - (PW+1)'(s1_q.p_ri);
    s2_d.sd = s1_q.sd;
    s2_d.er = s1_q.er;
    s2_d.ei = s1_q.ei;
    s2_d.nr = w_re[PW];
    s2_d.ni = w_im[PW];
    s2_d.ar = w_re[PW] ? MW'(-w_re) : MW'(w_re);
    s2_d.ai = w_im[PW] ? MW'(-w_im) : MW'(w_im);
  end

  always_ff @(posedge clk_i) begin
    if (adv[IdxS2]) s2_q <= s2_d;
  end

  // Stage 3: shift both magnitudes right together until each fits in NB bits.
  s3_t s3_d, s3_q;
  always_comb begin
    logic [XW-1:0]  or_v;
    logic [XW-1:0]  sh_r;
    logic [XW-1:0]  sh_i;
    logic [SHW-1:0] sft;
    or_v = XW'(s2_q.ar | s2_q.ai);
    sft  = SHW'(SMAX);
    for (int k = SMAX; k >= 0; k--) begin
      if ((or_v >> (NB + k)) == '0) sft = SHW'(k);
    end
    sh_r = XW'(s2_q.ar) >> sft;
    sh_i = XW'(s2_q.ai) >> sft;
    s3_d.sd   = s2_q.sd;
    s3_d.er   = s2_q.er;
    s3_d.ei   = s2_q.ei;
    s3_d.an_r = sh_r[NB-1:0];
    s3_d.an_i = sh_i[NB-1:0];
    s3_d.wr   = s2_q.nr ? -$signed({1'b0, sh_r[NB-1:0]}) : $signed({1'b0, sh_r[NB-1:0]});
    s3_d.wi   = s2_q.ni ? -$signed({1'b0, sh_i[NB-1:0]}) : $signed({1'b0, sh_i[NB-1:0]});
  end

  always_ff @(posedge clk_i) begin
    if (adv[IdxS3]) s3_q <= s3_d;
  end

  // Stage 4: squares for |W| and the four products of E * W.
  s4_t s4_d, s4_q;
  always_comb begin
    s4_d.sd   = s3_q.sd;
    s4_d.sq_r = (2*NB)'(s3_q.an_r) * (2*NB)'(s3_q.an_r);
    s4_d.sq_i = (2*NB)'(s3_q.an_i) * (2*NB)'(s3_q.an_i);
    s4_d.x_rr = XPW'(s3_q.er) * XPW'(s3_q.wr);
    s4_d.x_ii = XPW'(s3_q.ei) * XPW'(s3_q.wi);
    s4_d.x_ri = XPW'(s3_q.er) * XPW'(s3_q.wi);
    s4_d.x_ir = XPW'(s3_q.ei) * XPW'(s3_q.wr);
  end

  always_ff @(posedge clk_i) begin
    if (adv[IdxS4]) s4_q <= s4_d;
  end

  // Stage 5: radicand and the two numerators.
  s5_t s5_d, s5_q;
  always_comb begin
    s5_d.sd     = s4_q.sd;
    s5_d.rad    = RW'(s4_q.sq_r) + RW'(s4_q.sq_i);
    s5_d.num_re = NW'(s4_q.x_rr) - NW'(s4_q.x_ii);
    s5_d.num_im = NW'(s4_q.x_ri) + NW'(s4_q.x_ir);
  end

  always_ff @(posedge clk_i) begin
    if (adv[IdxS5]) s5_q <= s5_d;
  end

  // Square root, two root bits per stage; numerators turn into magnitudes on the way.
  sq_t sq_in;
  sq_t sq_c [SQS+1];
  sq_t sq_q [SQS];

  always_comb begin
    sq_in.sd     = s5_q.sd;
    sq_in.rad    = s5_q.rad;
    sq_in.root   = '0;
    sq_in.rem    = '0;
    sq_in.neg_re = s5_q.num_re[NW-1];
    sq_in.neg_im = s5_q.num_im[NW-1];
    sq_in.mag_re = s5_q.num_re[NW-1] ? NW'(-s5_q.num_re) : NW'(s5_q.num_re);
    sq_in.mag_im = s5_q.num_im[NW-1] ? NW'(-s5_q.num_im) : NW'(s5_q.num_im);
  end

  assign sq_c[0] = sq_in;

  for (genvar j = 0; j < SQS; j++) begin : g_sqrt
    sq_t st;
    always_comb begin
      logic [NB+2:0] rem_sh;
      logic [NB+2:0] trial;
      st = sq_c[j];
      for (int t = 0; t < 2; t++) begin
        if (2 * j + t < NB + 1) begin
          rem_sh = {st.rem[NB:0], st.rad[RW-1 -: 2]};
          trial  = {st.root, 2'b01};
          st.rad = {st.rad[RW-3:0], 2'b00};
          if (rem_sh >= trial) begin
            st.rem  = rem_sh - trial;
            st.root = {st.root[NB-1:0], 1'b1};
          end else begin
            st.rem  = rem_sh;
            st.root = {st.root[NB-1:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[IdxSq+j]) sq_q[j] <= st;
    end

    assign sq_c[j+1] = sq_q[j];
  end

  // Divider setup: add half the divisor for round-half-away, then take the top bits
  // as the starting remainder, which stays below the divisor.
  dv_t dv0_d, dv0_q;
  always_comb begin
    logic [NB:0]   m;
    logic [DW-1:0] d_re;
    logic [DW-1:0] d_im;
    m = (sq_c[SQS].root == '0) ? (NB+1)'(1) : sq_c[SQS].root;
    d_re = DW'(sq_c[SQS].mag_re) + DW'(m >> 1);
    d_im = DW'(sq_c[SQS].mag_im) + DW'(m >> 1);
    dv0_d.sd     = sq_c[SQS].sd;
    dv0_d.m      = m;
    dv0_d.r_re   = (NB+2)'(d_re >> QB);
    dv0_d.r_im   = (NB+2)'(d_im >> QB);
    dv0_d.dl_re  = d_re[QB-1:0];
    dv0_d.dl_im  = d_im[QB-1:0];
    dv0_d.q_re   = '0;
    dv0_d.q_im   = '0;
    dv0_d.neg_re = sq_c[SQS].neg_re;
    dv0_d.neg_im = sq_c[SQS].neg_im;
  end

  always_ff @(posedge clk_i) begin
    if (adv[IdxDv0]) dv0_q <= dv0_d;
  end

  // Two restoring dividers side by side, two quotient bits per stage.
  dv_t dv_c [DVS+1];
  dv_t dv_q [DVS];

  assign dv_c[0] = dv0_q;

  for (genvar j = 0; j < DVS; j++) begin : g_div
    dv_t st;
    always_comb begin
      logic [NB+1:0] rs_re;
      logic [NB+1:0] rs_im;
      st = dv_c[j];
      for (int t = 0; t < 2; t++) begin
        if (2 * j + t < QB) begin
          rs_re    = {st.r_re[NB:0], st.dl_re[QB-1]};
          rs_im    = {st.r_im[NB:0], st.dl_im[QB-1]};
          st.dl_re = {st.dl_re[QB-2:0], 1'b0};
          st.dl_im = {st.dl_im[QB-2:0], 1'b0};
          if (rs_re >= {1'b0, st.m}) begin
            st.r_re = rs_re - {1'b0, st.m};
            st.q_re = {st.q_re[QB-2:0], 1'b1};
          end else begin
            st.r_re = rs_re;
            st.q_re = {st.q_re[QB-2:0], 1'b0};
          end
          if (rs_im >= {1'b0, st.m}) begin
            st.r_im = rs_im - {1'b0, st.m};
            st.q_im = {st.q_im[QB-2:0], 1'b1};
          end else begin
            st.r_im = rs_im;
            st.q_im = {st.q_im[QB-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[IdxDv+j]) dv_q[j] <= st;
    end

    assign dv_c[j+1] = dv_q[j];
  end

  // Output stage: apply signs, saturate, pick the special cases.
  out_t out_d, out_q;
  always_comb begin
    logic [SW-1:0] v_re;
    logic [SW-1:0] v_im;
    logic [QB-1:0] qr;
    logic [QB-1:0] qi;
    qr = dv_c[DVS].q_re;
    qi = dv_c[DVS].q_im;
    if (dv_c[DVS].neg_re) begin
      if ((|qr[QB-1:SW]) || (qr[SW-1] && (|qr[SW-2:0]))) v_re = {1'b1, {(SW-1){1'b0}}};
      else v_re = -qr[SW-1:0];
    end else begin
      if (|qr[QB-1:SW-1]) v_re = {1'b0, {(SW-1){1'b1}}};
      else v_re = qr[SW-1:0];
    end
    if (dv_c[DVS].neg_im) begin
      if ((|qi[QB-1:SW]) || (qi[SW-1] && (|qi[SW-2:0]))) v_im = {1'b1, {(SW-1){1'b0}}};
      else v_im = -qi[SW-1:0];
    end else begin
      if (|qi[QB-1:SW-1]) v_im = {1'b0, {(SW-1){1'b1}}};
      else v_im = qi[SW-1:0];
    end
    priority if (dv_c[DVS].sd.deg) begin
      out_d.out_re = '0;
      out_d.out_im = '0;
    end else if (dv_c[DVS].sd.ro) begin
      out_d.out_re = dv_c[DVS].sd.ro_val;
      out_d.out_im = '0;
    end else begin
      out_d.out_re = v_re;
      out_d.out_im = v_im;
    end
    out_d.degenerate = dv_c[DVS].sd.deg;
  end

  always_ff @(posedge clk_i) begin
    if (adv[IdxOut]) out_q <= out_d;
  end

  assign rsp_o.valid      = v_q[IdxOut];
  assign rsp_o.out_re     = out_q.out_re;
  assign rsp_o.out_im     = out_q.out_im;
  assign rsp_o.degenerate = out_q.degenerate;

  // The input can only back up when the output holds a result that is not taken.
  a_full_only_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.ready |-> (v_q[IdxOut] && !rsp_o.ready))
    else $error("input stalled while the output is free");

  // A degenerate result always carries a zero bin.
  a_degenerate_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.degenerate) |-> (rsp_o.out_re == '0 && rsp_o.out_im == '0))
    else $error("degenerate result with nonzero bin");

  // A complex request with a zero start bin is flagged in the first stage.
  a_zero_start_flagged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready && !req_i.real_only &&
     req_i.start_re == '0 && req_i.start_im == '0) |=> (v_q[IdxS1] && s1_q.sd.deg))
    else $error("zero start bin not flagged");

  // For a nonzero product W the square root of |W|^2 is never zero.
  a_root_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[IdxDv0-1] && !sq_c[SQS].sd.ro && !sq_c[SQS].sd.deg) |-> (sq_c[SQS].root != '0))
    else $error("zero magnitude for a nondegenerate bin");

endmodule

// ===== sim/phase_vocoder_bin_update_unit_test.sv =====
// Testbench for phase_vocoder_bin_update_unit: random and directed bins are driven, each
// result is checked against a local fixed-point predictor of the rotated end bin.
// Depends on pvb_pkg, pvb_in_if, pvb_out_if and the top level of the block.
module phase_vocoder_bin_update_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import pvb_pkg::*;

  localparam int unsigned W = SampleWidthDef;
  localparam int unsigned NB = ((62 - W) < 31) ? (62 - W) : 31;
  localparam int unsigned NUM_RANDOM = 1680;
  localparam int unsigned PAUSE_AT = 900;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned WATCHDOG_LIMIT = 4000;

  typedef logic signed [W-1:0] sample_t;

  typedef struct packed {
    sample_t start_re, start_im, end_re, end_im, prev_re, prev_im;
    logic    real_only;
  } bin_req_t;

  typedef struct packed {
    sample_t out_re, out_im;
    logic    degenerate;
  } bin_rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  pvb_in_if  req_if ();
  pvb_out_if rsp_if ();

  phase_vocoder_bin_update_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  bin_req_t    pending_bins[$];
  bin_rsp_t    expected_bins[$];
  int unsigned accepted_cnt = 0;
  int unsigned sent_cnt = 0;
  int unsigned quiet_cycles = 0;
  bit          failed = 1'b0;

  function automatic longint sat_sample(longint v);
    longint hi, lo;
    hi = (longint'(1) <<< (W - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Rounds to nearest with ties away from zero.
  function automatic longint round_div(longint n, longint unsigned m);
    longint unsigned a, q;
    a = (n < 0) ? longint'(-n) : n;
    q = (a + m / 2) / m;
    return (n < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic bin_rsp_t rotate_bin(bin_req_t b);
    bin_rsp_t r;
    longint sr, si, er, ei, pr, pi, pwr, pwi, wr, wi;
    longint unsigned ar, ai, mag;
    bit nr, ni;
    sr = b.start_re; si = b.start_im; er = b.end_re; ei = b.end_im;
    pr = b.prev_re;  pi = b.prev_im;
    r = '0;
    if (b.real_only) begin
      if (sr == 0 || pr == 0) r.degenerate = 1'b1;
      else r.out_re = sample_t'(sat_sample(((sr < 0) != (pr < 0)) ? -er : er));
    end else if ((sr == 0 && si == 0) || (pr == 0 && pi == 0)) begin
      r.degenerate = 1'b1;
    end else begin
      pwr = pr * sr + pi * si;
      pwi = pi * sr - pr * si;
      nr = pwr < 0;
      ni = pwi < 0;
      ar = nr ? -pwr : pwr;
      ai = ni ? -pwi : pwi;
      while (ar >= (64'd1 << NB) || ai >= (64'd1 << NB)) begin
        ar = ar >> 1;
        ai = ai >> 1;
      end
      mag = int_sqrt(ar * ar + ai * ai);
      if (mag == 0) mag = 1;
      wr = nr ? -longint'(ar) : longint'(ar);
      wi = ni ? -longint'(ai) : longint'(ai);
      r.out_re = sample_t'(sat_sample(round_div(er * wr - ei * wi, mag)));
      r.out_im = sample_t'(sat_sample(round_div(er * wi + ei * wr, mag)));
    end
    return r;
  endfunction

  function automatic sample_t pick_sample(int unsigned kind);
    case (kind)
      0: return sample_t'($urandom);
      1: return sample_t'($urandom_range(0, 127) - 64);
      2: return '0;
      default: begin
        case ($urandom_range(0, 3))
          0: return {1'b1, {(W-1){1'b0}}};
          1: return {1'b0, {(W-1){1'b1}}};
          2: return '1;
          default: return sample_t'(1);
        endcase
      end
    endcase
  endfunction

  function automatic bin_req_t random_bin();
    bin_req_t b;
    int unsigned kind;
    kind = $urandom_range(0, 9);
    kind = (kind < 5) ? 0 : (kind < 7) ? 1 : (kind < 8) ? 3 : $urandom_range(0, 3);
    b.start_re  = pick_sample(kind);
    b.start_im  = pick_sample(kind);
    b.end_re    = pick_sample($urandom_range(0, 9) < 8 ? 0 : 3);
    b.end_im    = pick_sample($urandom_range(0, 9) < 8 ? 0 : 3);
    b.prev_re   = pick_sample(kind);
    b.prev_im   = pick_sample(kind);
    // Occasionally zero part or all of the start or previous bin to hit the degenerate path.
    if ($urandom_range(0, 15) == 0) begin
      b.start_re = '0;
      if ($urandom_range(0, 1)) b.start_im = '0;
    end
    if ($urandom_range(0, 15) == 0) begin
      b.prev_re = '0;
      if ($urandom_range(0, 1)) b.prev_im = '0;
    end
    b.real_only = ($urandom_range(0, 7) == 0);
    return b;
  endfunction

  function automatic bin_req_t make_bin(sample_t sr, sample_t si, sample_t er, sample_t ei,
                                        sample_t pr, sample_t pi, logic ro);
    bin_req_t b;
    b.start_re = sr; b.start_im = si; b.end_re = er; b.end_im = ei;
    b.prev_re = pr; b.prev_im = pi; b.real_only = ro;
    return b;
  endfunction

  // Idle percentages for sender and receiver, by test phase.
  function automatic int unsigned send_idle_pct();
    if (accepted_cnt < 600) return 29;
    if (accepted_cnt < 1200) return 80;
    return 0;
  endfunction

  function automatic int unsigned recv_idle_pct();
    if (accepted_cnt < 600) return 80;
    if (accepted_cnt < 1200) return 29;
    return 0;
  endfunction

  initial begin
    sample_t mx, mn;
    mx = {1'b0, {(W-1){1'b1}}};
    mn = {1'b1, {(W-1){1'b0}}};
    req_if.valid = 1'b0;
    req_if.start_re = '0; req_if.start_im = '0; req_if.end_re = '0;
    req_if.end_im = '0; req_if.prev_re = '0; req_if.prev_im = '0;
    req_if.real_only = 1'b0;
    rsp_if.ready = 1'b0;

    pending_bins.push_back(make_bin(mx, mx, mx, mx, mx, mx, 1'b0));
    pending_bins.push_back(make_bin(mn, mn, mn, mn, mn, mn, 1'b0));
    pending_bins.push_back(make_bin(mn, mx, mx, mn, mx, mn, 1'b0));
    pending_bins.push_back(make_bin(1, 0, mx, 0, 1, 0, 1'b0));
    pending_bins.push_back(make_bin(0, 1, mn, mx, 0, -1, 1'b0));
    pending_bins.push_back(make_bin(-1, -1, mn, mn, 1, 1, 1'b0));
    pending_bins.push_back(make_bin(1, 1, mx, mx, mx, mn, 1'b0));
    // Zero start or previous bin in a complex bin.
    pending_bins.push_back(make_bin(0, 0, mx, mx, 5, 7, 1'b0));
    pending_bins.push_back(make_bin(3, -2, mx, mx, 0, 0, 1'b0));
    pending_bins.push_back(make_bin(0, 0, mn, mn, 0, 0, 1'b0));
    // Real-only bins: signs, zero real part with nonzero imaginary, negated minimum.
    pending_bins.push_back(make_bin(mx, mn, 1234, mx, mx, mn, 1'b1));
    pending_bins.push_back(make_bin(-1, 0, 1234, 0, mx, 0, 1'b1));
    pending_bins.push_back(make_bin(mn, 0, mn, 0, 1, 0, 1'b1));
    pending_bins.push_back(make_bin(mn, mx, mn, mx, mn, mx, 1'b1));
    pending_bins.push_back(make_bin(0, mx, mx, mx, 5, mx, 1'b1));
    pending_bins.push_back(make_bin(7, mx, mx, mx, 0, mn, 1'b1));
    pending_bins.push_back(make_bin(mx, 0, mx, mn, mn, 0, 1'b1));
    pending_bins.push_back(make_bin(2, 3, -5, 9, -4, 6, 1'b0));
    for (int unsigned i = 0; i < NUM_RANDOM; i++) pending_bins.push_back(random_bin());

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Checked between edges so that the queues and the request are settled.
    do @(negedge clk_i);
    while (pending_bins.size() != 0 || req_if.valid || expected_bins.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (!failed) begin
      $display("phase_vocoder_bin_update_unit test passed");
    end else begin
      $display("phase_vocoder_bin_update_unit test failed");
    end
    $finish;
  end

  // Request driver.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else if (!req_if.valid || req_if.ready) begin
      // Hold off once until the pipeline has fully drained.
      if (pending_bins.size() != 0 && $urandom_range(0, 99) >= send_idle_pct() &&
          !(sent_cnt == PAUSE_AT && (req_if.valid || expected_bins.size() != 0))) begin
        bin_req_t b;
        b = pending_bins.pop_front();
        req_if.valid     <= 1'b1;
        req_if.start_re  <= b.start_re;
        req_if.start_im  <= b.start_im;
        req_if.end_re    <= b.end_re;
        req_if.end_im    <= b.end_im;
        req_if.prev_re   <= b.prev_re;
        req_if.prev_im   <= b.prev_im;
        req_if.real_only <= b.real_only;
        sent_cnt <= sent_cnt + 1;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Response side: backpressure, prediction on accept, checking and watchdog.
  always @(posedge clk_i) begin
    bin_rsp_t want;
    bit       moved;
    moved = 1'b0;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct());
      if (req_if.valid && req_if.ready) begin
        moved = 1'b1;
        accepted_cnt <= accepted_cnt + 1;
        expected_bins.push_back(rotate_bin(make_bin(req_if.start_re, req_if.start_im,
          req_if.end_re, req_if.end_im, req_if.prev_re, req_if.prev_im, req_if.real_only)));
      end
      if (rsp_if.valid && rsp_if.ready) begin
        moved = 1'b1;
        if (expected_bins.size() == 0) begin
          failed = 1'b1;
          $display("%0t: unexpected result re=%0d im=%0d degenerate=%0b", $time,
                   rsp_if.out_re, rsp_if.out_im, rsp_if.degenerate);
        end else begin
          want = expected_bins.pop_front();
          if (rsp_if.out_re !== want.out_re) begin
            failed = 1'b1;
            $display("%0t: out_re expected %0d actual %0d", $time, want.out_re,
                     rsp_if.out_re);
          end
          if (rsp_if.out_im !== want.out_im) begin
            failed = 1'b1;
            $display("%0t: out_im expected %0d actual %0d", $time, want.out_im,
                     rsp_if.out_im);
          end
          if (rsp_if.degenerate !== want.degenerate) begin
            failed = 1'b1;
            $display("%0t: degenerate expected %0b actual %0b", $time, want.degenerate,
                     rsp_if.degenerate);
          end
        end
      end
      quiet_cycles <= moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("phase_vocoder_bin_update_unit test failed");
        $finish;
      end
    end
  end

endmodule
